### rtl/fpb_pkg.sv
// Shared types, constants and codes for the flash page buffer loader.
package fpb_pkg;

   // Sizes; both byte counts are powers of two.
   localparam int PAGE_BYTES = 64;
   localparam int FLASH_BYTES = 8192;
   localparam int READ_BURST = 16;

   localparam int PAGE_AW = $clog2(PAGE_BYTES);
   localparam int FLASH_AW = $clog2(FLASH_BYTES);
   localparam int BURST_W = (READ_BURST > 1) ? $clog2(READ_BURST) : 1;

   localparam int IQ_DEPTH = 2;
   localparam int IQ_AW = 1;
   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW = 2;

   localparam logic [1:0] KIND_BUS_RESET = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic [1:0] REPLY_COUNT = 2'd0;
   localparam logic [1:0] REPLY_DATA = 2'd1;
   localparam logic [1:0] REPLY_BOOT = 2'd2;

   localparam logic [7:0] CMD_READ = 8'h00;
   localparam logic [7:0] CMD_WRITE = 8'h01;
   localparam logic [7:0] CMD_BOOT = 8'h02;

   localparam logic [7:0] COMMAND_BYTES = 8'd3;
   localparam logic [15:0] BUS_RESET_COUNT = 16'd3;
   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last_byte;
   } fpb_req_type;

   typedef struct packed {
      logic [1:0]  reply_kind;
      logic [15:0] reply_value;
      logic        reply_last;
   } fpb_rsp_type;

   typedef enum logic [1:0] {
      OP_BUS_RESET,
      OP_BYTE,
      OP_READ_REQ
   } fpb_op_code_type;

   typedef struct packed {
      fpb_op_code_type op;
      logic [7:0]      data_byte;
      logic            last_byte;
   } fpb_op_type;

   typedef struct packed {
      logic op_pop;
      logic clearing;
   } fpb_back_status_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_READ,
      MODE_WRITE,
      MODE_BOOT
   } fpb_mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_WAIT,
      ST_DECODE,
      ST_FLUSH,
      ST_LOAD,
      ST_STORE,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_EMIT,
      ST_BOOT2
   } fpb_state_type;

endpackage

### rtl/flash_page_buffer_bootloader.sv
// Top level of the flash page buffer loader: input queue, sequencer and result queue.
// After reset it erases the flash and page buffer to 0xFF, one byte per cycle, holding
// req_full high meanwhile. Each received byte passes the sequencer's wait and decode
// states and each result word its emit state, which waits on a full result queue. The
// first byte of a write message that moves to a new page flushes a modified page and
// then reloads the buffer, one byte per cycle, as each array has one write and one read
// port. A read request walks the address, data and emit states per returned byte, after
// flushing a modified page. Up to two words wait in the input queue and four result
// words in the output queue, so either side may stall without losing words.
module flash_page_buffer_bootloader (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  fpb_pkg::fpb_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output fpb_pkg::fpb_rsp_type rsp_data
);
   import fpb_pkg::*;

   fpb_back_status_type back_status;
   logic                op_valid;
   fpb_op_type          op_data;
   logic                rsp_push;
   fpb_rsp_type         rsp_word;
   logic                rsp_full;

   fpb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .back_status (back_status),
      .op_valid    (op_valid),
      .op_data     (op_data)
   );

   fpb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (op_valid),
      .op_data     (op_data),
      .back_status (back_status),
      .rsp_push    (rsp_push),
      .rsp_word    (rsp_word),
      .rsp_full    (rsp_full)
   );

   fpb_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_word),
      .full      (rsp_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("Result word pushed into a full result queue.");

   a_boot_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.reply_kind == REPLY_BOOT) |-> rsp_data.reply_last)
      else $error("Boot request word is not the final word of its input.");

   a_data_is_byte: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.reply_kind == REPLY_DATA) |-> (rsp_data.reply_value[15:8] == 8'h00))
      else $error("Read data word carries more than one byte.");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !op_valid)
      else $error("Input word queued during the erase pass.");
`endif

endmodule

### rtl/fpb_front.sv
// Input side: accepts bus words, classifies them and queues them for the sequencer, dropping words of unknown kind.
module fpb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  fpb_pkg::fpb_req_type         req_data,
   input  fpb_pkg::fpb_back_status_type back_status,
   output logic                         op_valid,
   output fpb_pkg::fpb_op_type          op_data
);
   import fpb_pkg::*;

   fpb_op_type       q_ff [IQ_DEPTH];
   logic [IQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IQ_AW:0]   count_ff, count_in;
   logic             q_full;
   logic             accept;
   logic             keep;
   logic             push;
   logic             pop;
   fpb_op_type       op_new;

   assign q_full = (count_ff == (IQ_AW + 1)'(IQ_DEPTH));
   assign req_full = q_full | back_status.clearing;
   assign accept = req_push & ~req_full;
   assign push = accept & keep;
   assign pop = back_status.op_pop & op_valid;
   assign op_valid = (count_ff != '0);
   assign op_data = q_ff[rd_ptr_ff];

   always_comb begin
      keep = 1'b1;
      op_new.op = OP_BYTE;
      op_new.data_byte = req_data.data_byte;
      op_new.last_byte = req_data.last_byte;
      unique case (req_data.kind)
         KIND_BUS_RESET: op_new.op = OP_BUS_RESET;
         KIND_BYTE: op_new.op = OP_BYTE;
         KIND_READ: op_new.op = OP_READ_REQ;
         default: keep = 1'b0;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

### rtl/fpb_back.sv
// Sequencer that owns the page buffer and flash arrays and produces result words.
module fpb_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         op_valid,
   input  fpb_pkg::fpb_op_type          op_data,
   output fpb_pkg::fpb_back_status_type back_status,
   output logic                         rsp_push,
   output fpb_pkg::fpb_rsp_type         rsp_word,
   input  logic                         rsp_full
);
   import fpb_pkg::*;

   fpb_state_type       state_ff, state_in;
   fpb_state_type       emit_next_ff, emit_next_in;
   fpb_state_type       flush_next_ff, flush_next_in;
   fpb_mode_type        mode_ff, mode_in;
   logic [15:0]         addr_ff, addr_in;
   logic [15:0]         base_ff, base_in;
   logic                dirty_ff, dirty_in;
   logic [23:0]         cmd_ff, cmd_in;
   logic [7:0]          cnt_ff, cnt_in;
   fpb_op_type          cur_ff, cur_in;
   fpb_rsp_type         res_ff, res_in;
   logic [PAGE_AW:0]    idx_ff, idx_in;
   logic [BURST_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic [FLASH_AW-1:0] clr_ff, clr_in;

   logic [7:0]          flash_mem_ff [FLASH_BYTES];
   logic [7:0]          page_mem_ff [PAGE_BYTES];
   logic [7:0]          fl_rdata_ff;
   logic [7:0]          pg_rdata_ff;
   logic                fl_we;
   logic [FLASH_AW-1:0] fl_waddr;
   logic [FLASH_AW-1:0] fl_raddr;
   logic [7:0]          fl_wdata;
   logic                pg_we;
   logic [PAGE_AW-1:0]  pg_waddr;
   logic [PAGE_AW-1:0]  pg_raddr;
   logic [7:0]          pg_wdata;
   logic                op_pop;

   logic [7:0]          cnt_inc;
   logic [23:0]         cmd_shift;
   logic                cmd_ok;
   logic [15:0]         new_base;
   logic                page_hit;
   logic                idx_done;
   logic [PAGE_AW:0]    idx_m1;
   logic [15:0]         flush_addr;
   logic [15:0]         load_addr;
   logic [16:0]         addr_sum;
   logic [15:0]         rd_next_addr;
   logic                rd_last;
   logic [15:0]         addr_plus;

   function automatic logic [15:0] page_base(input logic [15:0] a);
      page_base = {a[15:PAGE_AW], {PAGE_AW{1'b0}}};
   endfunction

   function automatic logic [15:0] room_left(input logic [15:0] a);
      room_left = 16'(PAGE_BYTES) - 16'(a[PAGE_AW-1:0]);
   endfunction

   assign cnt_inc = (cnt_ff == 8'hFF) ? cnt_ff : cnt_ff + 8'd1;
   assign cmd_shift = {cmd_ff[15:0], cur_ff.data_byte};
   assign cmd_ok = (cnt_inc == COMMAND_BYTES);
   assign new_base = page_base(addr_ff);
   assign page_hit = (base_ff == new_base);
   assign idx_done = (idx_ff == (PAGE_AW + 1)'(PAGE_BYTES));
   assign idx_m1 = idx_ff - 1'b1;
   assign flush_addr = base_ff + 16'(idx_m1);
   assign load_addr = new_base + 16'(idx_ff);
   assign addr_plus = addr_ff + 16'd1;
   assign addr_sum = {1'b0, addr_ff} + 17'd1;
   assign rd_next_addr = (addr_sum >= 17'(FLASH_BYTES)) ? 16'd0 : addr_sum[15:0];
   assign rd_last = (rd_cnt_ff == BURST_W'(READ_BURST - 1));

   assign back_status = '{op_pop: op_pop, clearing: (state_ff == ST_CLEAR)};
   assign rsp_word = res_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == FLASH_AW'(FLASH_BYTES - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (op_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (cur_ff.op)
               OP_BUS_RESET: state_in = ST_EMIT;
               OP_READ_REQ: begin
                  if (mode_ff != MODE_READ) begin
                     state_in = ST_WAIT;
                  end else if (dirty_ff) begin
                     state_in = ST_FLUSH;
                  end else begin
                     state_in = ST_RD_ADDR;
                  end
               end
               default: begin
                  unique case (mode_ff)
                     MODE_IDLE: begin
                        if (!cur_ff.last_byte) begin
                           state_in = ST_WAIT;
                        end else if (cmd_ok && cmd_shift[23:16] == CMD_BOOT && dirty_ff) begin
                           state_in = ST_FLUSH;
                        end else begin
                           state_in = ST_EMIT;
                        end
                     end
                     MODE_WRITE: begin
                        if (cnt_ff == 8'd0 && !page_hit) begin
                           state_in = dirty_ff ? ST_FLUSH : ST_LOAD;
                        end else begin
                           state_in = ST_STORE;
                        end
                     end
                     default: state_in = cur_ff.last_byte ? ST_EMIT : ST_WAIT;
                  endcase
               end
            endcase
         end
         ST_FLUSH: begin
            if (idx_done) begin
               state_in = flush_next_ff;
            end
         end
         ST_LOAD: begin
            if (idx_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: state_in = cur_ff.last_byte ? ST_EMIT : ST_WAIT;
         ST_RD_ADDR: state_in = ST_RD_DATA;
         ST_RD_DATA: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_full) begin
               state_in = emit_next_ff;
            end
         end
         ST_BOOT2: state_in = ST_EMIT;
         default: state_in = ST_WAIT;
      endcase
   end

   always_comb begin
      emit_next_in = emit_next_ff;
      flush_next_in = flush_next_ff;
      mode_in = mode_ff;
      addr_in = addr_ff;
      base_in = base_ff;
      dirty_in = dirty_ff;
      cmd_in = cmd_ff;
      cnt_in = cnt_ff;
      cur_in = cur_ff;
      res_in = res_ff;
      idx_in = idx_ff;
      rd_cnt_in = rd_cnt_ff;
      clr_in = clr_ff;
      op_pop = 1'b0;
      rsp_push = 1'b0;
      fl_we = 1'b0;
      fl_waddr = '0;
      fl_wdata = '0;
      fl_raddr = '0;
      pg_we = 1'b0;
      pg_waddr = '0;
      pg_wdata = '0;
      pg_raddr = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            fl_we = 1'b1;
            fl_waddr = clr_ff;
            fl_wdata = ERASED_BYTE;
            pg_we = 1'b1;
            pg_waddr = clr_ff[PAGE_AW-1:0];
            pg_wdata = ERASED_BYTE;
            clr_in = clr_ff + 1'b1;
         end
         ST_WAIT: begin
            op_pop = op_valid;
            if (op_valid) begin
               cur_in = op_data;
            end
         end
         ST_DECODE: begin
            idx_in = '0;
            rd_cnt_in = '0;
            emit_next_in = ST_WAIT;
            res_in.reply_kind = REPLY_COUNT;
            res_in.reply_value = 16'd0;
            res_in.reply_last = 1'b1;
            unique case (cur_ff.op)
               OP_BUS_RESET: begin
                  mode_in = MODE_IDLE;
                  cmd_in = '0;
                  cnt_in = '0;
                  res_in.reply_value = BUS_RESET_COUNT;
               end
               OP_READ_REQ: flush_next_in = ST_RD_ADDR;
               default: begin
                  unique case (mode_ff)
                     MODE_IDLE: begin
                        cnt_in = cnt_inc;
                        if (cnt_ff < COMMAND_BYTES) begin
                           cmd_in = cmd_shift;
                        end
                        if (cur_ff.last_byte) begin
                           cmd_in = '0;
                           cnt_in = '0;
                           if (cmd_ok) begin
                              addr_in = cmd_shift[15:0];
                              unique case (cmd_shift[23:16])
                                 CMD_READ: mode_in = MODE_READ;
                                 CMD_WRITE: begin
                                    mode_in = MODE_WRITE;
                                    res_in.reply_value = room_left(cmd_shift[15:0]);
                                 end
                                 CMD_BOOT: begin
                                    mode_in = MODE_BOOT;
                                    res_in.reply_last = 1'b0;
                                    emit_next_in = ST_BOOT2;
                                    flush_next_in = ST_EMIT;
                                 end
                                 default: mode_in = mode_ff;
                              endcase
                           end
                        end
                     end
                     MODE_WRITE: flush_next_in = ST_LOAD;
                     default: begin
                        cnt_in = cnt_inc;
                        if (cur_ff.last_byte) begin
                           cmd_in = '0;
                           cnt_in = '0;
                        end
                     end
                  endcase
               end
            endcase
         end
         ST_FLUSH: begin
            pg_raddr = idx_ff[PAGE_AW-1:0];
            if (idx_ff != '0) begin
               fl_we = 1'b1;
               fl_waddr = flush_addr[FLASH_AW-1:0];
               fl_wdata = pg_rdata_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_done) begin
               idx_in = '0;
               dirty_in = 1'b0;
            end
         end
         ST_LOAD: begin
            fl_raddr = load_addr[FLASH_AW-1:0];
            if (idx_ff != '0) begin
               pg_we = 1'b1;
               pg_waddr = idx_m1[PAGE_AW-1:0];
               pg_wdata = fl_rdata_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_done) begin
               idx_in = '0;
               base_in = new_base;
               dirty_in = 1'b0;
            end
         end
         ST_STORE: begin
            pg_we = 1'b1;
            pg_waddr = addr_ff[PAGE_AW-1:0];
            pg_wdata = cur_ff.data_byte;
            addr_in = addr_plus;
            dirty_in = 1'b1;
            cnt_in = cnt_inc;
            if (cur_ff.last_byte) begin
               cnt_in = '0;
               cmd_in = '0;
               res_in.reply_kind = REPLY_COUNT;
               res_in.reply_value = room_left(addr_plus);
               res_in.reply_last = 1'b1;
               emit_next_in = ST_WAIT;
            end
         end
         ST_RD_ADDR: fl_raddr = addr_ff[FLASH_AW-1:0];
         ST_RD_DATA: begin
            res_in.reply_kind = REPLY_DATA;
            res_in.reply_value = {8'h00, fl_rdata_ff};
            res_in.reply_last = rd_last;
            addr_in = rd_next_addr;
            rd_cnt_in = rd_cnt_ff + 1'b1;
            emit_next_in = rd_last ? ST_WAIT : ST_RD_ADDR;
         end
         ST_EMIT: rsp_push = !rsp_full;
         ST_BOOT2: begin
            res_in.reply_kind = REPLY_BOOT;
            res_in.reply_value = addr_ff;
            res_in.reply_last = 1'b1;
            emit_next_in = ST_WAIT;
         end
         default: clr_in = clr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         emit_next_ff <= ST_WAIT;
         flush_next_ff <= ST_WAIT;
         mode_ff <= MODE_IDLE;
         addr_ff <= '0;
         base_ff <= '0;
         dirty_ff <= 1'b0;
         cmd_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
         rd_cnt_ff <= '0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         emit_next_ff <= emit_next_in;
         flush_next_ff <= flush_next_in;
         mode_ff <= mode_in;
         addr_ff <= addr_in;
         base_ff <= base_in;
         dirty_ff <= dirty_in;
         cmd_ff <= cmd_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         rd_cnt_ff <= rd_cnt_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (fl_we) begin
         flash_mem_ff[fl_waddr] <= fl_wdata;
      end
      fl_rdata_ff <= flash_mem_ff[fl_raddr];
   end

   always_ff @(posedge clock) begin
      if (pg_we) begin
         page_mem_ff[pg_waddr] <= pg_wdata;
      end
      pg_rdata_ff <= page_mem_ff[pg_raddr];
   end

endmodule

### rtl/fpb_rsp_fifo.sv
// Result queue between the sequencer and the result ports.
module fpb_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fpb_pkg::fpb_rsp_type push_data,
   output logic                 full,
   output logic                 empty,
   input  logic                 pop,
   output fpb_pkg::fpb_rsp_type pop_data
);
   import fpb_pkg::*;

   fpb_rsp_type      q_ff [OQ_DEPTH];
   logic [OQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OQ_AW:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full = (count_ff == (OQ_AW + 1)'(OQ_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;
   assign pop_data = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
